>>> design/swtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtc_pkg
// Types and constants shared by the square-wave timer setting calculator.
// ----------------------------------------------------------------------------
package swtc_pkg;

  localparam int unsigned FreqW        = 16;
  localparam int unsigned CmpW         = 16;
  localparam int unsigned CodeW        = 3;
  localparam int unsigned NumW         = 24;
  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned NumStages    = NumW / BitsPerStage;

  // Timer clock in hertz. The dividend is this clock already divided by
  // twice the prescale, so only a division by the frequency remains.
  localparam logic [NumW-1:0] ClockHz = NumW'(16000000);
  localparam logic [NumW-1:0] NumDiv1   = ClockHz >> 1;
  localparam logic [NumW-1:0] NumDiv8   = ClockHz >> 4;
  localparam logic [NumW-1:0] NumDiv64  = ClockHz >> 7;
  localparam logic [NumW-1:0] NumDiv256 = ClockHz >> 9;

  localparam logic [FreqW-1:0] LimitDiv1  = FreqW'(245);
  localparam logic [FreqW-1:0] LimitDiv8  = FreqW'(31);
  localparam logic [FreqW-1:0] LimitDiv64 = FreqW'(4);

  localparam logic [CmpW-1:0] CompareMax = {CmpW{1'b1}};

  typedef enum logic [CodeW-1:0] {
    PRESC_NONE   = 3'd0,
    PRESC_DIV1   = 3'd1,
    PRESC_DIV8   = 3'd2,
    PRESC_DIV64  = 3'd3,
    PRESC_DIV256 = 3'd4
  } presc_e;

  // Payload carried down the divider pipeline.
  typedef struct packed {
    logic             setting;
    presc_e           code;
    logic [FreqW-1:0] freq;
    logic [FreqW-1:0] rem;
    logic [NumW-1:0]  num;
    logic [NumW-1:0]  quo;
  } div_t;

endpackage

>>> design/swtc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtc_front
// Picks the prescaler and the matching dividend, and loads the divider state.
// ----------------------------------------------------------------------------
module swtc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [swtc_pkg::FreqW-1:0]    freq_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output swtc_pkg::div_t                data_o
);

  logic           valid_q;
  swtc_pkg::div_t data_d;
  swtc_pkg::div_t data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.setting = (freq_i != '0);
    data_d.freq    = freq_i;
    data_d.rem     = '0;
    data_d.quo     = '0;
    priority if (freq_i == '0) begin
      data_d.code = swtc_pkg::PRESC_NONE;
      data_d.num  = '0;
    end else if (freq_i >= swtc_pkg::LimitDiv1) begin
      data_d.code = swtc_pkg::PRESC_DIV1;
      data_d.num  = swtc_pkg::NumDiv1;
    end else if (freq_i >= swtc_pkg::LimitDiv8) begin
      data_d.code = swtc_pkg::PRESC_DIV8;
      data_d.num  = swtc_pkg::NumDiv8;
    end else if (freq_i >= swtc_pkg::LimitDiv64) begin
      data_d.code = swtc_pkg::PRESC_DIV64;
      data_d.num  = swtc_pkg::NumDiv64;
    end else begin
      data_d.code = swtc_pkg::PRESC_DIV256;
      data_d.num  = swtc_pkg::NumDiv256;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/swtc_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtc_div_stage
// One register stage of the restoring divider, retiring four quotient bits.
// ----------------------------------------------------------------------------
module swtc_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  swtc_pkg::div_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output swtc_pkg::div_t data_o
);

  logic                         valid_q;
  swtc_pkg::div_t               data_d;
  swtc_pkg::div_t               data_q;
  logic [swtc_pkg::FreqW:0]     trial;

  assign ready_o = !valid_q || ready_i;

  // Shift one dividend bit into the partial remainder per step and subtract
  // the frequency when it fits.
  always_comb begin
    data_d = data_i;
    trial  = '0;
    for (int i = 0; i < swtc_pkg::BitsPerStage; i++) begin
      trial      = {data_d.rem, data_d.num[swtc_pkg::NumW-1]};
      data_d.num = {data_d.num[swtc_pkg::NumW-2:0], 1'b0};
      if (trial >= {1'b0, data_d.freq}) begin
        data_d.rem = swtc_pkg::FreqW'(trial - {1'b0, data_d.freq});
        data_d.quo = {data_d.quo[swtc_pkg::NumW-2:0], 1'b1};
      end else begin
        data_d.rem = trial[swtc_pkg::FreqW-1:0];
        data_d.quo = {data_d.quo[swtc_pkg::NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/swtc_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtc_post
// Turns the quotient into the compare value and holds the result beat.
// ----------------------------------------------------------------------------
module swtc_post (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  swtc_pkg::div_t               data_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic                         setting_o,
  output logic [swtc_pkg::CodeW-1:0]   code_o,
  output logic [swtc_pkg::CmpW-1:0]    cmp_o
);

  logic                        valid_q;
  logic                        setting_q;
  logic [swtc_pkg::CodeW-1:0]  code_q;
  logic [swtc_pkg::CmpW-1:0]   cmp_q;
  logic [swtc_pkg::CmpW-1:0]   cmp_d;
  logic [swtc_pkg::NumW-1:0]   quo_m1;

  assign ready_o = !valid_q || !stall_i;
  assign quo_m1  = data_i.quo - swtc_pkg::NumW'(1);

  // Compare value is quotient minus one, saturated; zero for no setting or a zero quotient.
  always_comb begin
    priority if (!data_i.setting || (data_i.quo == '0)) begin
      cmp_d = '0;
    end else if (quo_m1 > swtc_pkg::NumW'(swtc_pkg::CompareMax)) begin
      cmp_d = swtc_pkg::CompareMax;
    end else begin
      cmp_d = quo_m1[swtc_pkg::CmpW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      setting_q <= data_i.setting;
      code_q    <= data_i.code;
      cmp_q     <= cmp_d;
    end
  end

  assign valid_o   = valid_q;
  assign setting_o = setting_q;
  assign code_o    = code_q;
  assign cmp_o     = cmp_q;

endmodule

>>> design/square_wave_timer_setting_calc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_wave_timer_setting_calc_core
// Prescaler and compare value calculator for a 16 MHz toggle-on-compare timer.
// ----------------------------------------------------------------------------
// Each input beat carries a requested square-wave frequency in hertz and
// produces exactly one result beat with the prescaler code and the compare
// value 16000000 / (2 * prescale * f) - 1, saturated to 16 bits. A frequency
// of zero returns setting_valid low with a zero code and compare value. The
// block accepts one beat every clock cycle while the result side does not
// stall, and presents each result through eight registers: the input
// register, loaded at the accepting edge together with the prescaler choice,
// six pipeline stages of a restoring divider that each retire four quotient
// bits, and one output register that forms the compare value. Every stage
// only advances when the stage behind it has room, so stalls on the result
// side back up through the pipeline without dropping or repeating a beat.
// ----------------------------------------------------------------------------
module square_wave_timer_setting_calc_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [swtc_pkg::FreqW-1:0]   frequency_hz_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         setting_valid_o,
  output logic [swtc_pkg::CodeW-1:0]   prescaler_code_o,
  output logic [swtc_pkg::CmpW-1:0]    compare_value_o
);

  // Handshake and payload between consecutive pipeline stages. Index 0 is the
  // front end output; index k is the output of divider stage k.
  logic           stg_valid [swtc_pkg::NumStages+1];
  logic           stg_ready [swtc_pkg::NumStages+1];
  swtc_pkg::div_t stg_data  [swtc_pkg::NumStages+1];

  logic           front_ready;

  assign in_stall_o = !front_ready;

  // Prescaler selection and divider setup.
  swtc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .freq_i  (frequency_hz_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .data_o  (stg_data[0])
  );

  // Divider pipeline: the dividend is shifted through one bit per step.
  for (genvar k = 0; k < swtc_pkg::NumStages; k++) begin : g_div
    swtc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .data_i  (stg_data[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .data_o  (stg_data[k+1])
    );
  end

  // Compare value formation and the result register.
  swtc_post u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stg_valid[swtc_pkg::NumStages]),
    .ready_o   (stg_ready[swtc_pkg::NumStages]),
    .data_i    (stg_data[swtc_pkg::NumStages]),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .setting_o (setting_valid_o),
    .code_o    (prescaler_code_o),
    .cmp_o     (compare_value_o)
  );

endmodule
